// ===== src/wis_pkg.sv =====
// Shared types, codes and helper functions for the wave equation RHS stencil.
package wis_pkg;

    localparam int WIS_MAX_POINTS = 1024;
    localparam int IDX_W          = 10;
    localparam int ACC_W          = 36;
    localparam int SC_DEPTH       = 7;

    typedef logic signed [31:0] q_t;
    typedef logic signed [51:0] wide_t;
    typedef logic signed [49:0] qm_t;

    typedef struct packed {
        q_t         first_field;
        q_t         second_field;
        q_t         source_value;
        q_t         coef_a;
        q_t         coef_b;
        q_t         coef_c;
        q_t         coef_d;
        q_t         bnd_value_now;
        q_t         bnd_value_before;
        q_t         bnd_linear_now;
        q_t         bnd_linear_before;
        logic       end_of_grid;
    } in_item_t;

    typedef struct packed {
        q_t               rhs_value;
        logic [IDX_W-1:0] grid_index;
        logic             written;
        logic             last_result;
    } out_item_t;

    // Configuration register indexes
    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_LOWER_KIND = 3'd1;
    localparam logic [2:0] REG_UPPER_KIND = 3'd2;
    localparam logic [2:0] REG_USE_SOURCE = 3'd3;
    localparam logic [2:0] REG_TIME_STEP  = 3'd4;
    localparam logic [2:0] REG_GRID_STEP  = 3'd5;
    localparam logic [2:0] REG_LAMBDA     = 3'd6;
    localparam logic [2:0] REG_INV_K2     = 3'd7;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_INIT   = 2'd1;
    localparam logic [1:0] MODE_TERM   = 2'd2;

    localparam logic [1:0] KIND_DIRICHLET = 2'd0;
    localparam logic [1:0] KIND_NEUMANN   = 2'd1;
    localparam logic [1:0] KIND_ROBIN     = 2'd2;

    // Scratch slots of the sequencer
    localparam logic [2:0] SC_BC  = 3'd0;
    localparam logic [2:0] SC_BP  = 3'd1;
    localparam logic [2:0] SC_AC  = 3'd2;
    localparam logic [2:0] SC_AP  = 3'd3;
    localparam logic [2:0] SC_TAC = 3'd4;
    localparam logic [2:0] SC_TAP = 3'd5;
    localparam logic [2:0] SC_FAC = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE, ST_START, ST_MUL, ST_POST, ST_EMIT, ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        JOB_NONE, JOB_ZERO, JOB_MID, JOB_LOW, JOB_UP
    } job_t;

    typedef enum logic [3:0] {
        AS_K, AS_H, AS_A, AS_B, AS_DC, AS_2A, AS_2B, AS_2LC, AS_FAC,
        AS_2AB, AS_AB, AS_2LCT, AS_DCT, AS_BF, AS_AC, AS_AP
    } asel_t;

    typedef enum logic [3:0] {
        BS_V0, BS_V1, BS_V2, BS_V3, BS_V4, BS_V5, BS_A, BS_B, BS_DC, BS_W,
        BS_CO, BS_BD0, BS_BD1, BS_BD2, BS_BD3
    } bsel_t;

    typedef enum logic [1:0] {
        P_ACC, P_Q, P_Q2, P_Q2R
    } post_t;

    typedef struct packed {
        asel_t      asel;
        bsel_t      bsel;
        post_t      post;
        logic [2:0] dest;
        logic       neg;
        logic       last;
    } mop_t;

    localparam wide_t Q_MAX = 52'sd2147483647;
    localparam wide_t Q_MIN = -52'sd2147483648;

    // Saturate to the signed 32-bit range
    function automatic q_t sat32(wide_t x);
        q_t r;
        if (x > Q_MAX) begin
            r = 32'sh7fffffff;
        end else if (x < Q_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Micro-op table: one multiply per step
    function automatic mop_t micro_op(job_t job, logic nrm, logic init, logic upper,
                                      logic [3:0] step);
        mop_t m;
        m.asel = AS_A;
        m.bsel = BS_V0;
        m.post = P_ACC;
        m.dest = SC_BC;
        m.neg  = 1'b0;
        m.last = 1'b0;
        if (job == JOB_MID) begin
            if (nrm) begin
                unique case (step)
                    4'd0: begin m.asel = AS_B;   m.bsel = BS_V2; end
                    4'd1: begin m.asel = AS_DC;  m.bsel = BS_V1; m.neg = 1'b1; end
                    4'd2: begin m.asel = AS_A;   m.bsel = BS_V0; end
                    4'd3: begin m.asel = AS_2B;  m.bsel = BS_V5; end
                    4'd4: begin m.asel = AS_2LC; m.bsel = BS_V4; end
                    default: begin m.asel = AS_2A; m.bsel = BS_V3; m.last = 1'b1; end
                endcase
            end else begin
                unique case (step)
                    4'd0: begin m.asel = AS_2B;  m.bsel = BS_V2; end
                    4'd1: begin m.asel = AS_2LC; m.bsel = BS_V1; end
                    4'd2: begin m.asel = AS_2A;  m.bsel = BS_V0; end
                    4'd3: begin
                        m.asel = AS_K; m.bsel = BS_B; m.post = P_Q2; m.dest = SC_FAC;
                    end
                    4'd4: begin m.asel = AS_FAC; m.bsel = BS_V5; m.neg = init; end
                    4'd5: begin
                        m.asel = AS_K; m.bsel = BS_DC; m.post = P_Q2; m.dest = SC_FAC;
                    end
                    4'd6: begin m.asel = AS_FAC; m.bsel = BS_V4; m.neg = !init; end
                    4'd7: begin
                        m.asel = AS_K; m.bsel = BS_A; m.post = P_Q2; m.dest = SC_FAC;
                    end
                    default: begin
                        m.asel = AS_FAC; m.bsel = BS_V3; m.neg = init; m.last = 1'b1;
                    end
                endcase
            end
        end else begin
            unique case (step)
                4'd0: begin m.asel = AS_H; m.bsel = BS_BD0; m.post = P_Q2; m.dest = SC_BC; end
                4'd1: begin m.asel = AS_H; m.bsel = BS_BD1; m.post = P_Q2; m.dest = SC_BP; end
                4'd2: begin m.asel = AS_H; m.bsel = BS_BD2; m.post = P_Q2R; m.dest = SC_AC; end
                4'd3: begin m.asel = AS_H; m.bsel = BS_BD3; m.post = P_Q2R; m.dest = SC_AP; end
                4'd4: begin m.asel = AS_AC; m.bsel = BS_CO; m.post = P_Q; m.dest = SC_TAC; end
                4'd5: begin m.asel = AS_AP; m.bsel = BS_CO; m.post = P_Q; m.dest = SC_TAP; end
                4'd6: begin m.asel = AS_2AB;  m.bsel = BS_V0; end
                4'd7: begin m.asel = AS_2LCT; m.bsel = BS_V1; end
                4'd8: begin
                    if (nrm) begin
                        m.asel = AS_AB; m.bsel = BS_V2;
                    end else begin
                        m.asel = AS_K; m.bsel = BS_W; m.post = P_Q2; m.dest = SC_FAC;
                    end
                end
                4'd9: begin
                    if (nrm) begin
                        m.asel = AS_DCT; m.bsel = BS_V3; m.neg = 1'b1;
                    end else begin
                        m.asel = AS_FAC; m.bsel = BS_V3;
                    end
                end
                default: begin
                    m.asel = AS_BF; m.bsel = BS_CO; m.neg = upper; m.last = 1'b1;
                end
            endcase
        end
        return m;
    endfunction

endpackage

// ===== src/wave_implicit_rhs_stencil_top.sv =====
// Top level: RHS stencil for implicit 1-D wave equation steps, one shared multiplier.
// Each product is a 33x32 multiply (ST_MUL), then round, saturate and accumulate or store
// (ST_POST). A new point is accepted only after every result of the previous one is emitted;
// output stalls hold the sequencer. Lower end: 11 products. The last point of a pass also
// yields the upper-end result.
// Reset is synchronous: sequencer, point counter, config registers, output valid clear.
module wave_implicit_rhs_stencil_top #(
    parameter int MAX_POINTS = wis_pkg::WIS_MAX_POINTS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wis_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output wis_pkg::out_item_t m_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import wis_pkg::*;

    localparam int CW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

    // Configuration
    logic [1:0]  mode_reg, lower_kind_reg, upper_kind_reg;
    logic        use_source_reg;
    logic [31:0] time_step_reg, grid_step_reg;
    q_t          lambda_reg, inv_k2_reg;

    // Sequencer
    state_t        state_reg, state_next;
    logic          phase_reg;
    logic [3:0]    step_reg;
    job_t          job1_reg, job2_reg, cur_job;
    logic [CW-1:0] count_reg, idx_reg;
    in_item_t      item_reg;

    // Window of earlier points
    q_t wf0_reg, wf1_reg, ws0_reg, ws1_reg, wsrc_reg;
    q_t wcoef_reg [4];
    q_t lbd_reg   [4];

    // Working set of the current result
    q_t   wc_reg  [4];
    q_t   wv_reg  [6];
    q_t   wbd_reg [4];
    q_t   src_reg;
    logic upper_reg, robin_reg;
    q_t   sc_reg  [SC_DEPTH];

    logic signed [65:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    out_item_t               out_reg;
    logic                    m_valid_reg;

    logic       nrm, init, last_in, out_free;
    logic       lower_ok, upper_ok;
    mop_t       mop;
    wide_t      w_a, w_b, w_c, w_d, w_lam, w_tac, w_tap, w_bc, w_bp;
    q_t         co;
    logic signed [33:0] opa;
    q_t         opb;
    logic signed [65:0] rnd;
    qm_t        q_val;
    q_t         q_sat, q2_sat;
    logic signed [ACC_W-1:0] rsum;
    logic [CW-1:0]  idx_m1;
    logic [IDX_W-1:0] res_index;

    assign nrm      = !(mode_reg == MODE_INIT || mode_reg == MODE_TERM);
    assign init     = (mode_reg == MODE_INIT);
    assign lower_ok = (lower_kind_reg == KIND_NEUMANN || lower_kind_reg == KIND_ROBIN);
    assign upper_ok = (upper_kind_reg == KIND_NEUMANN || upper_kind_reg == KIND_ROBIN);
    assign last_in  = s_item.end_of_grid || (count_reg == CW'(MAX_POINTS - 1));
    assign cur_job  = phase_reg ? job2_reg : job1_reg;
    assign mop      = micro_op(cur_job, nrm, init, upper_reg, step_reg);
    assign out_free = !m_valid_reg || m_ready;

    // Widened operands for the factor arithmetic
    assign w_a   = 52'(wc_reg[0]);
    assign w_b   = 52'(wc_reg[1]);
    assign w_c   = 52'(wc_reg[2]);
    assign w_d   = 52'(wc_reg[3]);
    assign w_lam = nrm ? 52'(inv_k2_reg) : 52'(lambda_reg);
    assign w_tac = upper_reg ? -52'(sc_reg[SC_TAC]) : 52'(sc_reg[SC_TAC]);
    assign w_tap = upper_reg ? -52'(sc_reg[SC_TAP]) : 52'(sc_reg[SC_TAP]);
    assign w_bc  = 52'(sc_reg[SC_BC]);
    assign w_bp  = 52'(sc_reg[SC_BP]);
    assign co    = upper_reg ? wc_reg[1] : wc_reg[0];

    // Select the factor operand
    always_comb begin
        unique case (mop.asel)
            AS_K:    opa = signed'({2'b00, time_step_reg});
            AS_H:    opa = signed'({2'b00, grid_step_reg});
            AS_A:    opa = 34'(wc_reg[0]);
            AS_B:    opa = 34'(wc_reg[1]);
            AS_DC:   opa = 34'(sat32(w_d + w_c));
            AS_2A:   opa = 34'(sat32(w_a <<< 1));
            AS_2B:   opa = 34'(sat32(w_b <<< 1));
            AS_2LC:  opa = 34'(sat32((w_lam - w_c) <<< 1));
            AS_FAC:  opa = 34'(sc_reg[SC_FAC]);
            AS_2AB:  opa = 34'(sat32((w_a + w_b) <<< 1));
            AS_AB:   opa = 34'(sat32(w_a + w_b));
            AS_2LCT: opa = 34'(sat32((w_lam - w_c + w_tac) <<< 1));
            AS_DCT:  opa = 34'(sat32(w_d + w_c - w_tap));
            AS_BF:   opa = nrm ? 34'(sat32((w_bc <<< 1) + w_bp)) : 34'(sat32(w_bc <<< 1));
            AS_AC:   opa = 34'(sc_reg[SC_AC]);
            AS_AP:   opa = 34'(sc_reg[SC_AP]);
            default: opa = '0;
        endcase
    end

    // Select the value operand
    always_comb begin
        unique case (mop.bsel)
            BS_V0:   opb = wv_reg[0];
            BS_V1:   opb = wv_reg[1];
            BS_V2:   opb = wv_reg[2];
            BS_V3:   opb = wv_reg[3];
            BS_V4:   opb = wv_reg[4];
            BS_V5:   opb = wv_reg[5];
            BS_A:    opb = wc_reg[0];
            BS_B:    opb = wc_reg[1];
            BS_DC:   opb = sat32(w_d + w_c);
            BS_W:    opb = init ? sat32(w_d + w_c - w_a - w_b) : sat32(w_a + w_b - w_c - w_d);
            BS_CO:   opb = co;
            BS_BD0:  opb = wbd_reg[0];
            BS_BD1:  opb = wbd_reg[1];
            BS_BD2:  opb = wbd_reg[2];
            BS_BD3:  opb = wbd_reg[3];
            default: opb = '0;
        endcase
    end

    // Round the product to Q16.16 and saturate
    assign rnd    = prod_reg + 66'sd32768;
    assign q_val  = rnd[65:16];
    assign q_sat  = sat32(52'(q_val));
    assign q2_sat = sat32(52'(q_val) <<< 1);

    assign rsum      = acc_reg + (use_source_reg ? ACC_W'(src_reg) : '0);
    assign idx_m1    = idx_reg - CW'(1);
    assign res_index = phase_reg ? IDX_W'(idx_reg)
                     : ((idx_reg == '0) ? '0 : IDX_W'(idx_m1));

    // Next state and handshake
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (cur_job == JOB_NONE) begin
                    if (phase_reg) begin
                        state_next = ST_DONE;
                    end
                end else if (cur_job == JOB_ZERO) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_POST;
            end
            ST_POST: begin
                state_next = mop.last ? ST_EMIT : ST_MUL;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = phase_reg ? ST_DONE : ST_START;
                end
            end
            ST_DONE: begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_NORMAL;
            lower_kind_reg <= KIND_DIRICHLET;
            upper_kind_reg <= KIND_DIRICHLET;
            use_source_reg <= 1'b0;
            time_step_reg  <= '0;
            grid_step_reg  <= '0;
            lambda_reg     <= '0;
            inv_k2_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MODE:       mode_reg       <= cfg_data[1:0];
                REG_LOWER_KIND: lower_kind_reg <= cfg_data[1:0];
                REG_UPPER_KIND: upper_kind_reg <= cfg_data[1:0];
                REG_USE_SOURCE: use_source_reg <= cfg_data[0];
                REG_TIME_STEP:  time_step_reg  <= cfg_data;
                REG_GRID_STEP:  grid_step_reg  <= cfg_data;
                REG_LAMBDA:     lambda_reg     <= cfg_data;
                REG_INV_K2:     inv_k2_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Sequencer control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= 1'b0;
            step_reg    <= '0;
            count_reg   <= '0;
            job1_reg    <= JOB_NONE;
            job2_reg    <= JOB_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            // Classify the results an accepted item causes
            if (state_reg == ST_IDLE && s_valid) begin
                phase_reg <= 1'b0;
                count_reg <= last_in ? '0 : count_reg + CW'(1);
                if (count_reg == '0) begin
                    job1_reg <= last_in ? JOB_ZERO : JOB_NONE;
                end else if (count_reg == CW'(1)) begin
                    job1_reg <= lower_ok ? JOB_LOW : JOB_ZERO;
                end else begin
                    job1_reg <= JOB_MID;
                end
                if (last_in && count_reg != '0) begin
                    job2_reg <= upper_ok ? JOB_UP : JOB_ZERO;
                end else begin
                    job2_reg <= JOB_NONE;
                end
            end
            if (state_reg == ST_START) begin
                step_reg <= '0;
                if (cur_job == JOB_NONE && !phase_reg) begin
                    phase_reg <= 1'b1;
                end
            end
            if (state_reg == ST_POST && !mop.last) begin
                step_reg <= step_reg + 4'd1;
            end
            if (state_reg == ST_EMIT && out_free && !phase_reg) begin
                phase_reg <= 1'b1;
            end
            // Hold the result until taken
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            item_reg <= s_item;
            idx_reg  <= count_reg;
        end

        // Load the working set for the next result
        if (state_reg == ST_START) begin
            acc_reg <= '0;
            if (cur_job == JOB_UP) begin
                wc_reg[0] <= item_reg.coef_a;
                wc_reg[1] <= item_reg.coef_b;
                wc_reg[2] <= item_reg.coef_c;
                wc_reg[3] <= item_reg.coef_d;
                wbd_reg[0] <= item_reg.bnd_value_now;
                wbd_reg[1] <= item_reg.bnd_value_before;
                wbd_reg[2] <= item_reg.bnd_linear_now;
                wbd_reg[3] <= item_reg.bnd_linear_before;
                src_reg   <= item_reg.source_value;
                upper_reg <= 1'b1;
                robin_reg <= (upper_kind_reg == KIND_ROBIN);
                wv_reg[0] <= nrm ? ws0_reg : wf0_reg;
                wv_reg[1] <= nrm ? item_reg.second_field : item_reg.first_field;
                wv_reg[2] <= nrm ? wf0_reg : ws0_reg;
                wv_reg[3] <= nrm ? item_reg.first_field : item_reg.second_field;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    wc_reg[i]  <= wcoef_reg[i];
                    wbd_reg[i] <= lbd_reg[i];
                end
                src_reg   <= wsrc_reg;
                upper_reg <= 1'b0;
                robin_reg <= (lower_kind_reg == KIND_ROBIN);
                if (cur_job == JOB_MID) begin
                    wv_reg[0] <= wf1_reg;
                    wv_reg[1] <= wf0_reg;
                    wv_reg[2] <= item_reg.first_field;
                    wv_reg[3] <= ws1_reg;
                    wv_reg[4] <= ws0_reg;
                    wv_reg[5] <= item_reg.second_field;
                end else begin
                    wv_reg[0] <= nrm ? item_reg.second_field : item_reg.first_field;
                    wv_reg[1] <= nrm ? ws0_reg : wf0_reg;
                    wv_reg[2] <= nrm ? item_reg.first_field : item_reg.second_field;
                    wv_reg[3] <= nrm ? wf0_reg : ws0_reg;
                end
            end
        end

        // Multiply
        if (state_reg == ST_MUL) begin
            prod_reg <= 66'(opa) * 66'(opb);
        end

        // Round, saturate, then accumulate or store
        if (state_reg == ST_POST) begin
            unique case (mop.post)
                P_ACC: acc_reg <= mop.neg ? acc_reg - ACC_W'(q_sat) : acc_reg + ACC_W'(q_sat);
                P_Q:   sc_reg[mop.dest] <= q_sat;
                P_Q2:  sc_reg[mop.dest] <= q2_sat;
                P_Q2R: sc_reg[mop.dest] <= robin_reg ? q2_sat : '0;
                default: ;
            endcase
        end

        // Load the output register
        if (state_reg == ST_EMIT && out_free) begin
            out_reg.rhs_value   <= (cur_job == JOB_ZERO) ? '0 : sat32(52'(rsum));
            out_reg.grid_index  <= res_index;
            out_reg.written     <= (cur_job != JOB_ZERO);
            out_reg.last_result <= phase_reg || (idx_reg == '0);
        end

        // Advance the window
        if (state_reg == ST_DONE) begin
            wf1_reg      <= wf0_reg;
            wf0_reg      <= item_reg.first_field;
            ws1_reg      <= ws0_reg;
            ws0_reg      <= item_reg.second_field;
            wsrc_reg     <= item_reg.source_value;
            wcoef_reg[0] <= item_reg.coef_a;
            wcoef_reg[1] <= item_reg.coef_b;
            wcoef_reg[2] <= item_reg.coef_c;
            wcoef_reg[3] <= item_reg.coef_d;
            if (idx_reg == '0) begin
                lbd_reg[0] <= item_reg.bnd_value_now;
                lbd_reg[1] <= item_reg.bnd_value_before;
                lbd_reg[2] <= item_reg.bnd_linear_now;
                lbd_reg[3] <= item_reg.bnd_linear_before;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

endmodule

// ===== src/wis_chk.sv =====
// Port-level checker for the RHS stencil, bound to the top level.
module wis_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input wis_pkg::in_item_t  s_item,
    input logic               m_valid,
    input logic               m_ready,
    input wis_pkg::out_item_t m_item,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [2:0]         cfg_index,
    input logic [31:0]        cfg_data
);
    import wis_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // An unwritten end carries a zero value
    a_unwritten_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.written |-> m_item.rhs_value == 32'sd0)
        else $error("unwritten result with nonzero value");

    // One item at a time: not ready right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accepting an item");

    // Reset drops the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind wave_implicit_rhs_stencil_top wis_chk u_wis_chk (.*);

// ===== tb/wis_checker.sv =====
// Result checker for the wave equation RHS stencil: predicts and compares every result item.
module wis_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  wis_pkg::in_item_t  s_item,
    input  logic               m_valid,
    input  logic               m_ready,
    input  wis_pkg::out_item_t m_item,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 pending_count
);
    import wis_pkg::*;

    localparam int POINT_LIMIT = 1024;

    // shadow configuration
    logic [1:0] cur_mode, cur_lower, cur_upper;
    logic       cur_src;
    longint     k_step, h_step, lam_w, inv_k2;

    // shadow window
    longint     prev_first[2], prev_second[2], prev_source[2];
    longint     prev_coef[8];
    longint     low_bnd[4];
    int         next_index;

    out_item_t  rhs_queue[$];

    function automatic longint clip(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Q16.16 product with round half up
    function automatic longint qprod(longint a, longint b);
        longint q;
        q = a * b + 32768;
        return q >>> 16;
    endfunction

    function automatic longint wterm(longint f, longint v);
        return clip(qprod(clip(f), v));
    endfunction

    function automatic bit normal_mode();
        return cur_mode != MODE_INIT && cur_mode != MODE_TERM;
    endfunction

    function automatic longint cur_lam();
        return normal_mode() ? inv_k2 : lam_w;
    endfunction

    function automatic longint boundary_rhs(bit upper, longint cf[4], longint xnb,
                                            longint xs, longint ynb, longint ys,
                                            longint bd[4], bit robin);
        longint a, b, c, d, co, sg, bc, bp, ac, ap, sum, bf, w;
        a = cf[0]; b = cf[1]; c = cf[2]; d = cf[3];
        co = upper ? b : a;
        sg = upper ? -1 : 1;
        bc = clip(2 * qprod(h_step, bd[0]));
        bp = clip(2 * qprod(h_step, bd[1]));
        ac = robin ? clip(2 * qprod(h_step, bd[2])) : 0;
        ap = robin ? clip(2 * qprod(h_step, bd[3])) : 0;
        sum = wterm(2 * (a + b), xnb);
        sum += wterm(2 * (cur_lam() - c + sg * wterm(ac, co)), xs);
        if (normal_mode()) begin
            sum += wterm(a + b, ynb);
            sum -= wterm(d + c - sg * wterm(ap, co), ys);
            bf = clip(2 * bc + bp);
        end else begin
            w = clip(cur_mode == MODE_INIT ? d + c - a - b : a + b - c - d);
            sum += wterm(2 * qprod(k_step, w), ys);
            bf = clip(2 * bc);
        end
        sum += sg * wterm(bf, co);
        return sum;
    endfunction

    function automatic longint interior_rhs(longint u0[3], longint u1[3]);
        longint a, b, c, d, sum, sg;
        a = prev_coef[0]; b = prev_coef[1]; c = prev_coef[2]; d = prev_coef[3];
        if (normal_mode()) begin
            sum = wterm(b, u0[2]) - wterm(d + c, u0[1]) + wterm(a, u0[0])
                + wterm(2 * b, u1[2]) + wterm(2 * (cur_lam() - c), u1[1])
                + wterm(2 * a, u1[0]);
        end else begin
            sg = (cur_mode == MODE_INIT) ? -1 : 1;
            sum = wterm(2 * b, u0[2]) + wterm(2 * (cur_lam() - c), u0[1])
                + wterm(2 * a, u0[0])
                + sg * wterm(2 * qprod(k_step, b), u1[2])
                - sg * wterm(2 * qprod(k_step, clip(d + c)), u1[1])
                + sg * wterm(2 * qprod(k_step, a), u1[0]);
        end
        return sum;
    endfunction

    function automatic void push_rhs(longint r, int idx, bit wr, bit last);
        out_item_t o;
        o.rhs_value   = q_t'(clip(r));
        o.grid_index  = idx[IDX_W-1:0];
        o.written     = wr;
        o.last_result = last;
        rhs_queue.push_back(o);
    endfunction

    function automatic void predict_point(in_item_t it);
        longint f, s, src, r;
        longint cf[4], bd[4], u0[3], u1[3], pc[4];
        bit last, nrm, robin;
        f = longint'(it.first_field);
        s = longint'(it.second_field);
        src = longint'(it.source_value);
        cf[0] = longint'(it.coef_a); cf[1] = longint'(it.coef_b);
        cf[2] = longint'(it.coef_c); cf[3] = longint'(it.coef_d);
        bd[0] = longint'(it.bnd_value_now); bd[1] = longint'(it.bnd_value_before);
        bd[2] = longint'(it.bnd_linear_now); bd[3] = longint'(it.bnd_linear_before);
        for (int i = 0; i < 4; i++) pc[i] = prev_coef[i];
        last = it.end_of_grid || next_index >= POINT_LIMIT - 1;
        nrm = normal_mode();
        if (next_index == 0) begin
            low_bnd = bd;
            if (last) push_rhs(0, 0, 1'b0, 1'b1);
        end else if (next_index == 1) begin
            if (cur_lower == KIND_NEUMANN || cur_lower == KIND_ROBIN) begin
                robin = cur_lower == KIND_ROBIN;
                r = boundary_rhs(1'b0, pc, nrm ? s : f,
                                 nrm ? prev_second[0] : prev_first[0], nrm ? f : s,
                                 nrm ? prev_first[0] : prev_second[0], low_bnd, robin);
                if (cur_src) r += prev_source[0];
                push_rhs(r, 0, 1'b1, 1'b0);
            end else begin
                push_rhs(0, 0, 1'b0, 1'b0);
            end
        end else begin
            u0[0] = prev_first[1]; u0[1] = prev_first[0]; u0[2] = f;
            u1[0] = prev_second[1]; u1[1] = prev_second[0]; u1[2] = s;
            r = interior_rhs(u0, u1);
            if (cur_src) r += prev_source[0];
            push_rhs(r, next_index - 1, 1'b1, 1'b0);
        end
        if (last && next_index >= 1) begin
            if (cur_upper == KIND_NEUMANN || cur_upper == KIND_ROBIN) begin
                robin = cur_upper == KIND_ROBIN;
                r = boundary_rhs(1'b1, cf, nrm ? prev_second[0] : prev_first[0],
                                 nrm ? s : f,
                                 nrm ? prev_first[0] : prev_second[0], nrm ? f : s,
                                 bd, robin);
                if (cur_src) r += src;
                push_rhs(r, next_index, 1'b1, 1'b1);
            end else begin
                push_rhs(0, next_index, 1'b0, 1'b1);
            end
        end
        prev_first[1] = prev_first[0];   prev_first[0] = f;
        prev_second[1] = prev_second[0]; prev_second[0] = s;
        prev_source[1] = prev_source[0]; prev_source[0] = src;
        for (int i = 0; i < 4; i++) begin
            prev_coef[4+i] = prev_coef[i];
            prev_coef[i] = cf[i];
        end
        next_index = last ? 0 : next_index + 1;
    endfunction

    assign pending_count = rhs_queue.size();

    // track config, predict on input, compare on output
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            cur_mode <= MODE_NORMAL; cur_lower <= KIND_DIRICHLET;
            cur_upper <= KIND_DIRICHLET; cur_src <= 1'b0;
            k_step = 0; h_step = 0; lam_w = 0; inv_k2 = 0;
            prev_first = '{0, 0}; prev_second = '{0, 0}; prev_source = '{0, 0};
            prev_coef = '{0, 0, 0, 0, 0, 0, 0, 0};
            low_bnd = '{0, 0, 0, 0};
            next_index = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MODE:       cur_mode <= cfg_data[1:0];
                    REG_LOWER_KIND: cur_lower <= cfg_data[1:0];
                    REG_UPPER_KIND: cur_upper <= cfg_data[1:0];
                    REG_USE_SOURCE: cur_src <= cfg_data[0];
                    REG_TIME_STEP:  k_step = longint'({32'd0, cfg_data});
                    REG_GRID_STEP:  h_step = longint'({32'd0, cfg_data});
                    REG_LAMBDA:     lam_w = longint'($signed(cfg_data));
                    REG_INV_K2:     inv_k2 = longint'($signed(cfg_data));
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_point(s_item);
            if (m_valid && m_ready) begin
                if (rhs_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result item %p", m_item);
                end else begin
                    want = rhs_queue.pop_front();
                    if (want !== m_item) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p, got %p", want, m_item);
                    end
                end
            end
        end
    end

    initial fail_count = 0;
endmodule

// ===== tb/testbench.sv =====
// Testbench top: drives points and register writes into the RHS stencil and gives the verdict.
module testbench;
    import wis_pkg::*;

    logic       aclk, aresetn;
    logic       s_valid, s_ready, m_valid, m_ready, cfg_valid, cfg_ready;
    in_item_t   s_item;
    out_item_t  m_item;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;
    int         fail_count, pending_count;
    bit         stall_free;

    wave_implicit_rhs_stencil_top dut (.*);

    wis_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // end the run if the block hangs
    initial begin
        #30000000;
        $display("testbench NOT OK");
        $finish;
    end

    // receiver stalls
    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_ready && m_valid) begin
                gap = stall_free ? 0 : $urandom_range(0, 8);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                    m_ready <= 1'b1;
                end
            end else if (!m_ready) begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait until every result is in, then let the block settle
    task automatic drain();
        while (pending_count != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic send_point(in_item_t it);
        int gap;
        gap = stall_free ? 0 : $urandom_range(0, 8);
        repeat (gap) @(posedge aclk);
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_q();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 8) << 16;
            3: return -($urandom_range(0, 8) << 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t rand_point(bit last);
        in_item_t it;
        it.first_field = pick_q();      it.second_field = pick_q();
        it.source_value = pick_q();     it.coef_a = pick_q();
        it.coef_b = pick_q();           it.coef_c = pick_q();
        it.coef_d = pick_q();           it.bnd_value_now = pick_q();
        it.bnd_value_before = pick_q(); it.bnd_linear_now = pick_q();
        it.bnd_linear_before = pick_q();
        it.end_of_grid = last;
        return it;
    endfunction

    task automatic set_config(logic [1:0] md, logic [1:0] lo, logic [1:0] up, bit src,
                              logic [31:0] k, logic [31:0] h, logic [31:0] lam,
                              logic [31:0] ik);
        write_reg(REG_MODE, {30'd0, md});
        write_reg(REG_LOWER_KIND, {30'd0, lo});
        write_reg(REG_UPPER_KIND, {30'd0, up});
        write_reg(REG_USE_SOURCE, {31'd0, src});
        write_reg(REG_TIME_STEP, k);
        write_reg(REG_GRID_STEP, h);
        write_reg(REG_LAMBDA, lam);
        write_reg(REG_INV_K2, ik);
    endtask

    task automatic random_config();
        set_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                   2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   pick_q(), pick_q(), pick_q(), pick_q());
    endtask

    task automatic send_pass(int len);
        for (int i = 0; i < len; i++) send_point(rand_point(i == len - 1));
    endtask

    initial begin
        in_item_t it;
        int sent;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = '0;
        stall_free = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, every mode and boundary kind, one-point pass
        set_config(MODE_NORMAL, KIND_NEUMANN, KIND_ROBIN, 1'b1, 32'h0001_0000,
                   32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
        it = '1;
        it.end_of_grid = 1'b0;
        send_point(it);
        it = '0;
        send_point(it);
        it = rand_point(1'b1);
        send_point(it);
        send_point(rand_point(1'b1));
        drain();
        set_config(MODE_INIT, KIND_ROBIN, KIND_NEUMANN, 1'b0, 32'hffffffff, 32'hffffffff,
                   32'h7fffffff, 32'h80000000);
        send_pass(4);
        drain();
        set_config(MODE_TERM, KIND_DIRICHLET, KIND_DIRICHLET, 1'b1, 32'h0, 32'h0,
                   32'h80000000, 32'h7fffffff);
        send_pass(3);
        drain();
        set_config(2'd3, 2'd3, KIND_ROBIN, 1'b0, 32'h8000, 32'h4000, 32'hffff0000, 32'h10000);
        send_pass(5);
        drain();

        // over-long pass wraps at the point limit
        stall_free = 1'b1;
        for (int i = 0; i < 1025; i++) send_point(rand_point(1'b0));
        send_point(rand_point(1'b1));
        drain();
        stall_free = 1'b0;

        // random passes, settings changed between them
        sent = 0;
        while (sent < 200) begin
            random_config();
            repeat ($urandom_range(1, 4)) begin
                int len;
                len = $urandom_range(1, 12);
                send_pass(len);
                sent += len;
            end
            // hold off until the block has no result outstanding
            drain();
            stall_free = ($urandom_range(0, 4) == 0);
        end

        drain();
        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
